### hdl/epld_pkg.sv
// Package for the EV pilot level detector: register indexes, level codes,
// millivolt thresholds mapped back to ADC counts, and the level classifier.
// No dependencies.
`default_nettype none

package epld_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int SAMPLE_W     = 12;
    localparam int VALUE_W      = 16;
    localparam int TIME_W       = 32;
    localparam int HOLD_W       = 16;
    localparam int GSIZE_W      = 5;
    localparam int GSHIFT_W     = 3;
    localparam int WGROUPS_W    = 11;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [GSIZE_W-1:0]   GSIZE_MAX     = 5'd16;
    localparam logic [GSIZE_W-1:0]   GSIZE_RST     = 5'd1;
    localparam logic [GSHIFT_W-1:0]  GSHIFT_RST    = 3'd0;
    localparam logic [WGROUPS_W-1:0] WGROUPS_RST   = 11'd320;
    localparam logic [HOLD_W-1:0]    HOLD_RST      = 16'd500;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_GROUP_SIZE    = 2'd0;
    localparam cfg_idx_t REG_GROUP_SHIFT   = 2'd1;
    localparam cfg_idx_t REG_WINDOW_GROUPS = 2'd2;
    localparam cfg_idx_t REG_HOLD_TIME     = 2'd3;

    localparam logic CH_CP = 1'b0;
    localparam logic CH_PP = 1'b1;

    typedef logic [2:0] level_t;
    localparam level_t CP_FAULT    = 3'd0;
    localparam level_t CP_3V       = 3'd1;
    localparam level_t CP_6V       = 3'd2;
    localparam level_t CP_9V       = 3'd3;
    localparam level_t CP_12V      = 3'd4;
    localparam level_t PP_32A      = 3'd0;
    localparam level_t PP_20A      = 3'd1;
    localparam level_t PP_13A      = 3'd2;
    localparam level_t PP_NO_CABLE = 3'd3;

    // mV = adc * MV_NUM / MV_DEN, so mV < T exactly when adc < ceil(T * MV_DEN / MV_NUM)
    localparam int MV_NUM = 806;
    localparam int MV_DEN = 1000;

    localparam logic [VALUE_W-1:0] CP_T_3V  = VALUE_W'((100  * MV_DEN + MV_NUM - 1) / MV_NUM);
    localparam logic [VALUE_W-1:0] CP_T_6V  = VALUE_W'((662  * MV_DEN + MV_NUM - 1) / MV_NUM);
    localparam logic [VALUE_W-1:0] CP_T_9V  = VALUE_W'((1344 * MV_DEN + MV_NUM - 1) / MV_NUM);
    localparam logic [VALUE_W-1:0] CP_T_12V = VALUE_W'((2026 * MV_DEN + MV_NUM - 1) / MV_NUM);
    localparam logic [VALUE_W-1:0] PP_T_20A = VALUE_W'((1129 * MV_DEN + MV_NUM - 1) / MV_NUM);
    localparam logic [VALUE_W-1:0] PP_T_13A = VALUE_W'((1678 * MV_DEN + MV_NUM - 1) / MV_NUM);
    localparam logic [VALUE_W-1:0] PP_T_NC  = VALUE_W'((2187 * MV_DEN + MV_NUM - 1) / MV_NUM);

    function automatic level_t classify(input logic chan, input logic [VALUE_W-1:0] adc);
        level_t lvl;
        if (chan == CH_CP) begin
            if (adc < CP_T_3V)       lvl = CP_FAULT;
            else if (adc < CP_T_6V)  lvl = CP_3V;
            else if (adc < CP_T_9V)  lvl = CP_6V;
            else if (adc < CP_T_12V) lvl = CP_9V;
            else                     lvl = CP_12V;
        end
        else begin
            if (adc < PP_T_20A)      lvl = PP_32A;
            else if (adc < PP_T_13A) lvl = PP_20A;
            else if (adc < PP_T_NC)  lvl = PP_13A;
            else                     lvl = PP_NO_CABLE;
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

### hdl/ev_pilot_level_detector.sv
// EV pilot level detector: the sample that closes a window passes from the input register
// to the window register, then the result register, before its result shows on out_valid.
// Throughput one sample per cycle while out_stall holds nothing back; a stalled result
// backs up through in_stall. Samples that close no window give no result.
// Reset (rst_n low, asynchronous) restores register defaults, clears the pipeline,
// the group and window accumulators and the per-channel debounce state.
// Depends on epld_pkg.
`default_nettype none

module ev_pilot_level_detector #(
    parameter int ADC_BITS = epld_pkg::ADC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire epld_pkg::cfg_idx_t                 cfg_index,
    input  wire logic [epld_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [epld_pkg::SAMPLE_W-1:0]      sample,
    input  wire logic                               channel,
    input  wire logic [epld_pkg::TIME_W-1:0]        now_ms,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    out_channel,
    output logic [epld_pkg::VALUE_W-1:0]            window_peak,
    output logic [epld_pkg::VALUE_W-1:0]            window_floor,
    output epld_pkg::level_t                        pending_level,
    output epld_pkg::level_t                        accepted_level,
    output logic [epld_pkg::VALUE_W-1:0]            accepted_peak,
    output logic                                    level_changed
);
    import epld_pkg::*;

    localparam int MASK_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((33'd1 << MASK_BITS) - 33'd1);
    localparam logic [VALUE_W-1:0] FLOOR_INIT =
        (ADC_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'(33'd1 << ADC_BITS);

    // configuration registers
    logic [GSIZE_W-1:0]   group_size_reg;
    logic [GSHIFT_W-1:0]  group_shift_reg;
    logic [WGROUPS_W-1:0] window_groups_reg;
    logic [HOLD_W-1:0]    hold_time_reg;

    // input stage
    logic                 s1_valid_reg;
    logic [SAMPLE_W-1:0]  s1_sample_reg;
    logic                 s1_chan_reg;
    logic [TIME_W-1:0]    s1_now_reg;

    // accumulator state
    logic [VALUE_W-1:0]   group_sum_reg, group_sum_next;
    logic [GSIZE_W-1:0]   group_count_reg, group_count_next;
    logic [WGROUPS_W-1:0] window_count_reg, window_count_next;
    logic [VALUE_W-1:0]   run_peak_reg, run_peak_next;
    logic [VALUE_W-1:0]   run_floor_reg, run_floor_next;

    // window-end stage
    logic                 s2_valid_reg;
    logic                 s2_chan_reg;
    logic [VALUE_W-1:0]   s2_peak_reg;
    logic [VALUE_W-1:0]   s2_floor_reg;
    logic [TIME_W-1:0]    s2_now_reg;

    // per-channel debounce state
    logic [VALUE_W-1:0]   pend_peak_reg [2];
    logic [TIME_W-1:0]    pend_since_reg [2];
    level_t               pend_code_reg [2];
    level_t               acc_code_reg [2];
    logic [VALUE_W-1:0]   acc_value_reg [2];

    // result register
    logic                 out_valid_reg;
    logic                 out_chan_reg;
    logic [VALUE_W-1:0]   out_peak_reg;
    logic [VALUE_W-1:0]   out_floor_reg;
    level_t               out_pend_reg;
    level_t               out_acc_reg;
    logic [VALUE_W-1:0]   out_acc_peak_reg;
    logic                 out_changed_reg;

    logic in_take, out_free, s2_move, s2_free, s1_use, win_close;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s2_move   = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_use    = s1_valid_reg && s2_free;
    assign in_stall  = s1_valid_reg && !s2_free;
    assign in_take   = in_valid && !in_stall;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg    <= GSIZE_RST;
            group_shift_reg   <= GSHIFT_RST;
            window_groups_reg <= WGROUPS_RST;
            hold_time_reg     <= HOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GROUP_SIZE:    group_size_reg    <= cfg_data[GSIZE_W-1:0];
                REG_GROUP_SHIFT:   group_shift_reg   <= cfg_data[GSHIFT_W-1:0];
                REG_WINDOW_GROUPS: window_groups_reg <= cfg_data[WGROUPS_W-1:0];
                REG_HOLD_TIME:     hold_time_reg     <= cfg_data[HOLD_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_use)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_chan_reg   <= channel;
            s1_now_reg    <= now_ms;
        end
    end

    // ---------------- group and window accumulation ----------------
    logic [GSIZE_W-1:0]   gsize;
    logic [WGROUPS_W-1:0] wgroups;
    logic [VALUE_W:0]     sum_wide;
    logic [VALUE_W-1:0]   sum_sat, avg, peak_upd, floor_upd;
    logic [GSIZE_W-1:0]   gcount_inc;
    logic [WGROUPS_W-1:0] wcount_inc;
    logic                 group_close;

    always_comb
    begin
        gsize = (group_size_reg == '0) ? GSIZE_W'(1)
              : ((group_size_reg > GSIZE_MAX) ? GSIZE_MAX : group_size_reg);
        wgroups = (window_groups_reg == '0) ? WGROUPS_W'(1) : window_groups_reg;

        sum_wide   = {1'b0, group_sum_reg}
                   + {{(VALUE_W + 1 - SAMPLE_W){1'b0}}, s1_sample_reg & SMP_MASK};
        sum_sat    = sum_wide[VALUE_W] ? {VALUE_W{1'b1}} : sum_wide[VALUE_W-1:0];
        gcount_inc = group_count_reg + GSIZE_W'(1);
        group_close = (gcount_inc >= gsize);

        avg        = sum_sat >> group_shift_reg;
        peak_upd   = (avg > run_peak_reg)  ? avg : run_peak_reg;
        floor_upd  = (avg < run_floor_reg) ? avg : run_floor_reg;
        wcount_inc = window_count_reg + WGROUPS_W'(1);
        win_close  = group_close && (wcount_inc >= wgroups);

        group_sum_next    = group_sum_reg;
        group_count_next  = group_count_reg;
        window_count_next = window_count_reg;
        run_peak_next     = run_peak_reg;
        run_floor_next    = run_floor_reg;

        if (s1_use)
        begin
            if (!group_close)
            begin
                group_sum_next   = sum_sat;
                group_count_next = gcount_inc;
            end
            else
            begin
                group_sum_next   = '0;
                group_count_next = '0;
                if (win_close)
                begin
                    window_count_next = '0;
                    run_peak_next     = '0;
                    run_floor_next    = FLOOR_INIT;
                end
                else
                begin
                    window_count_next = wcount_inc;
                    run_peak_next     = peak_upd;
                    run_floor_next    = floor_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_sum_reg    <= '0;
            group_count_reg  <= '0;
            window_count_reg <= '0;
            run_peak_reg     <= '0;
            run_floor_reg    <= FLOOR_INIT;
        end
        else
        begin
            group_sum_reg    <= group_sum_next;
            group_count_reg  <= group_count_next;
            window_count_reg <= window_count_next;
            run_peak_reg     <= run_peak_next;
            run_floor_reg    <= run_floor_next;
        end
    end

    // ---------------- window register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_use && win_close)
            s2_valid_reg <= 1'b1;
        else if (s2_move)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_use && win_close)
        begin
            s2_chan_reg  <= s1_chan_reg;
            s2_peak_reg  <= peak_upd;
            s2_floor_reg <= floor_upd;
            s2_now_reg   <= s1_now_reg;
        end
    end

    // ---------------- debounce ----------------
    level_t             fresh, pend_old, pend, acc_old, acc_new;
    logic [VALUE_W-1:0] ppeak, acc_val_new;
    logic [TIME_W-1:0]  since, dur;
    logic               hold_done, take_level;

    always_comb
    begin
        fresh    = classify(s2_chan_reg, s2_peak_reg);
        pend_old = pend_code_reg[s2_chan_reg];
        acc_old  = acc_code_reg[s2_chan_reg];

        // a new class restarts the hold timer
        if (fresh != pend_old)
        begin
            pend  = fresh;
            ppeak = s2_peak_reg;
            since = s2_now_reg;
        end
        else
        begin
            pend  = pend_old;
            ppeak = pend_peak_reg[s2_chan_reg];
            since = pend_since_reg[s2_chan_reg];
        end

        dur       = s2_now_reg - since;
        hold_done = dur > {{(TIME_W - HOLD_W){1'b0}}, hold_time_reg};

        // control pilot leaves every level but 6 V at once
        if (s2_chan_reg == CH_CP)
            take_level = (pend != acc_old) && ((acc_old != CP_6V) || hold_done);
        else
            take_level = (pend != acc_old) && hold_done;

        acc_new     = take_level ? pend  : acc_old;
        acc_val_new = take_level ? ppeak : acc_value_reg[s2_chan_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
            begin
                pend_peak_reg[c]  <= '0;
                pend_since_reg[c] <= '0;
                pend_code_reg[c]  <= CP_FAULT;
                acc_code_reg[c]   <= CP_FAULT;
                acc_value_reg[c]  <= '0;
            end
        end
        else if (s2_move)
        begin
            pend_peak_reg[s2_chan_reg]  <= ppeak;
            pend_since_reg[s2_chan_reg] <= since;
            pend_code_reg[s2_chan_reg]  <= pend;
            acc_code_reg[s2_chan_reg]   <= acc_new;
            acc_value_reg[s2_chan_reg]  <= acc_val_new;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_move)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_chan_reg     <= s2_chan_reg;
            out_peak_reg     <= s2_peak_reg;
            out_floor_reg    <= s2_floor_reg;
            out_pend_reg     <= pend;
            out_acc_reg      <= acc_new;
            out_acc_peak_reg <= acc_val_new;
            out_changed_reg  <= take_level;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_channel    = out_chan_reg;
    assign window_peak    = out_peak_reg;
    assign window_floor   = out_floor_reg;
    assign pending_level  = out_pend_reg;
    assign accepted_level = out_acc_reg;
    assign accepted_peak  = out_acc_peak_reg;
    assign level_changed  = out_changed_reg;

endmodule

`default_nettype wire

### hdl/epld_checker.sv
// Port-level checks for the EV pilot level detector, bound onto the top level.
// Depends on epld_pkg and ev_pilot_level_detector.
`default_nettype none

module epld_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic                            out_channel,
    input wire logic [epld_pkg::VALUE_W-1:0]    window_peak,
    input wire logic [epld_pkg::VALUE_W-1:0]    window_floor,
    input wire epld_pkg::level_t                pending_level,
    input wire epld_pkg::level_t                accepted_level,
    input wire logic [epld_pkg::VALUE_W-1:0]    accepted_peak,
    input wire logic                            level_changed
);
    import epld_pkg::*;

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_peak)
            && $stable(accepted_level) && $stable(accepted_peak) && $stable(level_changed))
        else $error("stalled result transaction changed");

    // a change always lands on the pending level
    a_change_to_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level_changed |-> accepted_level == pending_level)
        else $error("accepted level differs from pending level on change");

    // window floor never above window peak
    a_floor_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> window_floor <= window_peak)
        else $error("window floor above window peak");

    // proximity pilot has no code above no cable
    a_pp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_channel == CH_PP
            |-> accepted_level <= PP_NO_CABLE && pending_level <= PP_NO_CABLE)
        else $error("proximity pilot level out of range");

endmodule

bind ev_pilot_level_detector epld_checker u_epld_checker (.*);

`default_nettype wire

### tb/ev_pilot_level_detector_tb.sv
// Testbench for the EV pilot level detector: drives tagged ADC samples, predicts every
// window result (peak, floor, debounced levels) and checks each one as it leaves.
// Depends on epld_pkg and ev_pilot_level_detector.
`timescale 1ns / 1ps

module ev_pilot_level_detector_tb;

    import epld_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 200;
    localparam int          MAX_REPORTS   = 40;
    localparam int unsigned FLOOR_START   = 1 << ADC_BITS_DEF;
    localparam int unsigned SAMPLE_TOP    = (1 << SAMPLE_W) - 1;

    // level edges in millivolts
    localparam int unsigned CP_MV_3V  = 100;
    localparam int unsigned CP_MV_6V  = 662;
    localparam int unsigned CP_MV_9V  = 1344;
    localparam int unsigned CP_MV_12V = 2026;
    localparam int unsigned PP_MV_20A = 1129;
    localparam int unsigned PP_MV_13A = 1678;
    localparam int unsigned PP_MV_NC  = 2187;

    typedef struct {
        logic               chan;
        logic [VALUE_W-1:0] peak;
        logic [VALUE_W-1:0] trough;
        level_t             pend;
        level_t             held;
        logic [VALUE_W-1:0] held_peak;
        logic               changed;
    } window_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample;
    logic                  channel;
    logic [TIME_W-1:0]     now_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic                  out_channel;
    logic [VALUE_W-1:0]    window_peak;
    logic [VALUE_W-1:0]    window_floor;
    level_t                pending_level;
    level_t                accepted_level;
    logic [VALUE_W-1:0]    accepted_peak;
    logic                  level_changed;

    // register mirror
    logic [GSIZE_W-1:0]   reg_gsize   = GSIZE_RST;
    logic [GSHIFT_W-1:0]  reg_gshift  = GSHIFT_RST;
    logic [WGROUPS_W-1:0] reg_wgroups = WGROUPS_RST;
    logic [HOLD_W-1:0]    reg_hold    = HOLD_RST;

    // accumulator and debounce mirror
    int unsigned        grp_sum = 0;
    int unsigned        grp_fill = 0;
    int unsigned        win_fill = 0;
    int unsigned        win_hi = 0;
    int unsigned        win_lo = FLOOR_START;
    logic [VALUE_W-1:0] pend_peak [2] = '{0, 0};
    logic [TIME_W-1:0]  pend_time [2] = '{0, 0};
    level_t             held_level [2] = '{CP_FAULT, PP_32A};
    logic [VALUE_W-1:0] held_peak [2] = '{0, 0};

    window_result_t results_due [$];

    int          err_count = 0;
    int          samples_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    logic [31:0] clock_ms = 0;
    int unsigned level_edges [7] = '{125, 822, 1668, 2514, 1401, 2082, 2714};

    ev_pilot_level_detector DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .channel        (channel),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_channel    (out_channel),
        .window_peak    (window_peak),
        .window_floor   (window_floor),
        .pending_level  (pending_level),
        .accepted_level (accepted_level),
        .accepted_peak  (accepted_peak),
        .level_changed  (level_changed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic level_t level_of(input logic ch, input logic [VALUE_W-1:0] adc);
        int unsigned mv;
        mv = int'(adc) * MV_NUM / MV_DEN;
        if (ch == CH_CP)
        begin
            if (mv < CP_MV_3V)       return CP_FAULT;
            else if (mv < CP_MV_6V)  return CP_3V;
            else if (mv < CP_MV_9V)  return CP_6V;
            else if (mv < CP_MV_12V) return CP_9V;
            return CP_12V;
        end
        if (mv < PP_MV_20A)      return PP_32A;
        else if (mv < PP_MV_13A) return PP_20A;
        else if (mv < PP_MV_NC)  return PP_13A;
        return PP_NO_CABLE;
    endfunction

    function automatic int unsigned group_len();
        return (reg_gsize == 0) ? 1 : ((reg_gsize > GSIZE_MAX) ? GSIZE_MAX : reg_gsize);
    endfunction

    function automatic int unsigned window_len();
        return (reg_wgroups == 0) ? 1 : reg_wgroups;
    endfunction

    // Accumulate one sample; queue a result when it closes a window.
    function automatic void predict_window(input logic [SAMPLE_W-1:0] smp, input logic ch,
                                           input logic [TIME_W-1:0] t);
        int unsigned       avg;
        logic [TIME_W-1:0] held_for;
        level_t            fresh;
        level_t            pend;
        logic              ok;
        window_result_t    r;
        grp_sum = grp_sum + smp;
        if (grp_sum > 16'hFFFF)
            grp_sum = 16'hFFFF;
        grp_fill = (grp_fill + 1) & 5'h1F;
        if (grp_fill < group_len())
            return;
        avg = grp_sum >> reg_gshift;
        if (avg > win_hi) win_hi = avg;
        if (avg < win_lo) win_lo = avg;
        grp_sum = 0;
        grp_fill = 0;
        win_fill = (win_fill + 1) & 11'h7FF;
        if (win_fill < window_len())
            return;
        r.chan   = ch;
        r.peak   = win_hi[VALUE_W-1:0];
        r.trough = win_lo[VALUE_W-1:0];
        win_fill = 0;
        win_hi   = 0;
        win_lo   = FLOOR_START;

        pend  = level_of(ch, pend_peak[ch]);
        fresh = level_of(ch, r.peak);
        if (fresh != pend)
        begin
            pend_time[ch] = t;
            pend_peak[ch] = r.peak;
            pend = fresh;
        end
        held_for  = t - pend_time[ch];
        r.changed = 1'b0;
        if (pend != held_level[ch])
        begin
            // a CP level other than 6 V gives way at once; everything else waits the hold
            if (ch == CH_CP)
                ok = (held_level[ch] != CP_6V) || (held_for > reg_hold);
            else
                ok = held_for > reg_hold;
            if (ok)
            begin
                held_level[ch] = pend;
                held_peak[ch]  = pend_peak[ch];
                r.changed = 1'b1;
            end
        end
        r.pend      = pend;
        r.held      = held_level[ch];
        r.held_peak = held_peak[ch];
        results_due.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compare each result transaction with the oldest expectation.
    initial
    begin : result_checker
        window_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result with nothing expected, peak", window_peak, 0);
                else
                begin
                    want = results_due.pop_front();
                    if (out_channel !== want.chan)
                        report_mismatch("out_channel", out_channel, want.chan);
                    if (window_peak !== want.peak)
                        report_mismatch("window_peak", window_peak, want.peak);
                    if (window_floor !== want.trough)
                        report_mismatch("window_floor", window_floor, want.trough);
                    if (pending_level !== want.pend)
                        report_mismatch("pending_level", pending_level, want.pend);
                    if (accepted_level !== want.held)
                        report_mismatch("accepted_level", accepted_level, want.held);
                    if (accepted_peak !== want.held_peak)
                        report_mismatch("accepted_peak", accepted_peak, want.held_peak);
                    if (level_changed !== want.changed)
                        report_mismatch("level_changed", level_changed, want.changed);
                end
            end
        end
    end

    // Receiver stall: random, or a long hold-off on request.
    initial
    begin : result_stall_gen
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("ev_pilot_level_detector_tb: errors");
        $finish;
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic ch,
                               input logic [TIME_W-1:0] t);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= smp;
        channel  <= ch;
        now_ms   <= t;
        taken = 1'b0;
        // stall is stable between edges: sample it at the falling edge
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        predict_window(smp, ch, t);
        samples_sent++;
    endtask

    // Drop valid, let every expected result out, then let the pipeline settle.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] with_noise(input int unsigned v, input int w);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(v);
        if (w < CFG_DATA_W && $urandom_range(3) == 0)
            d = d | (CFG_DATA_W'($urandom()) << w);
        return d;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_GROUP_SIZE:    reg_gsize   = val[GSIZE_W-1:0];
            REG_GROUP_SHIFT:   reg_gshift  = val[GSHIFT_W-1:0];
            REG_WINDOW_GROUPS: reg_wgroups = val[WGROUPS_W-1:0];
            REG_HOLD_TIME:     reg_hold    = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int unsigned gs, input int unsigned sh,
                            input int unsigned wg, input int unsigned hold);
        write_reg(REG_GROUP_SIZE, with_noise(gs, GSIZE_W));
        write_reg(REG_GROUP_SHIFT, with_noise(sh, GSHIFT_W));
        write_reg(REG_WINDOW_GROUPS, with_noise(wg, WGROUPS_W));
        write_reg(REG_HOLD_TIME, with_noise(hold, HOLD_W));
        cfg_wr_en <= 1'b0;
    endtask

    // One full window under the reset register values; PP stays at its reset class.
    task automatic test_reset_defaults();
        int k;
        for (k = 0; k < 320; k++)
            push_sample($urandom_range(0, 1400), CH_PP, TIME_W'(k));
        drain_block();
    endtask

    task automatic test_directed();
        set_regs(1, 0, 1, 10);
        // CP debounce: instant moves away from non-6 V, held moves away from 6 V
        push_sample(0, CH_CP, 0);
        push_sample(4095, CH_CP, 1);
        push_sample(1000, CH_CP, 2);
        push_sample(4095, CH_CP, 3);
        push_sample(4095, CH_CP, 13);
        push_sample(4095, CH_CP, 14);
        // CP class edges
        push_sample(124, CH_CP, 20);
        push_sample(125, CH_CP, 21);
        push_sample(2513, CH_CP, 22);
        push_sample(2514, CH_CP, 23);
        // PP debounce, including a time that wraps
        push_sample(2000, CH_PP, 100);
        push_sample(2000, CH_PP, 111);
        push_sample(4095, CH_PP, 32'hFFFF_FFF8);
        push_sample(4095, CH_PP, 5);
        // PP class edges
        push_sample(1400, CH_PP, 6);
        push_sample(1401, CH_PP, 7);
        push_sample(2713, CH_PP, 8);
        push_sample(2714, CH_PP, 9);
        // group averages all above the initial floor
        drain_block();
        set_regs(2, 0, 1, 10);
        push_sample(4095, CH_CP, 30);
        push_sample(4095, CH_CP, 31);
        // shrink the group size with a group already part full
        drain_block();
        set_regs(4, 0, 1, 10);
        push_sample(10, CH_CP, 40);
        push_sample(20, CH_CP, 41);
        push_sample(30, CH_CP, 42);
        drain_block();
        set_regs(2, 0, 1, 10);
        push_sample(40, CH_CP, 43);
        // channel switches inside a window: the closing sample owns it
        drain_block();
        set_regs(1, 0, 2, 10);
        push_sample(500, CH_CP, 50);
        push_sample(3000, CH_PP, 51);
        drain_block();
    endtask

    // Mostly clean windows (one channel, steady level, advancing time), some noise.
    task automatic test_random_traffic(input int n_samples);
        int          first;
        int          next_cfg;
        int          n;
        int          k;
        int          v;
        int          spread;
        int unsigned e;
        logic        ch;
        logic [31:0] step;
        int unsigned base [2];
        first    = samples_sent;
        next_cfg = samples_sent;
        base[0]  = 0;
        base[1]  = 0;
        clock_ms = $urandom();
        while (samples_sent - first < n_samples)
        begin
            if (samples_sent >= next_cfg)
            begin
                drain_block();
                if ($urandom_range(3) != 0)
                begin
                    e = $urandom_range(0, 4);
                    set_regs(1 << e, e, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4),
                             $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 30));
                end
                else
                    set_regs($urandom_range(0, 31), $urandom_range(0, 7),
                             $urandom_range(0, 4), $urandom_range(0, 65535));
                next_cfg = samples_sent + $urandom_range(60, 200);
            end
            if ($urandom_range(9) < 8)
            begin
                ch = $urandom_range(1);
                if ($urandom_range(1))
                begin
                    case ($urandom_range(0, 2))
                        0:       base[ch] = $urandom_range(0, SAMPLE_TOP);
                        1:       base[ch] = level_edges[$urandom_range(0, 6)] + $urandom_range(0, 4) - 2;
                        default: base[ch] = $urandom_range(1) ? SAMPLE_TOP : 0;
                    endcase
                end
                case ($urandom_range(0, 4))
                    0:       step = 0;
                    1:       step = reg_hold;
                    2:       step = reg_hold + 1;
                    3:       step = $urandom_range(0, 3);
                    default: step = $urandom();
                endcase
                clock_ms = clock_ms + step;
                spread = $urandom_range(1) ? 0 : $urandom_range(1, 300);
                n = group_len() * window_len();
                for (k = 0; k < n; k++)
                begin
                    v = int'(base[ch]) - $urandom_range(0, spread) + $urandom_range(0, 1);
                    if (v < 0) v = 0;
                    if (v > SAMPLE_TOP) v = SAMPLE_TOP;
                    push_sample(v, ch, clock_ms);
                    if ($urandom_range(3) == 0)
                        clock_ms = clock_ms + 1;
                end
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    push_sample($urandom_range(0, SAMPLE_TOP), $urandom_range(1), $urandom());
            end
        end
        drain_block();
    endtask

    task automatic test_extreme_registers();
        int k;
        set_regs(0, 7, 0, 0);
        for (k = 0; k < 6; k++)
            push_sample($urandom_range(0, SAMPLE_TOP), $urandom_range(1), $urandom());
        drain_block();
        set_regs(31, 4, 2, 65535);
        for (k = 0; k < 32; k++)
            push_sample($urandom_range(3000, SAMPLE_TOP), $urandom_range(1), $urandom());
        drain_block();
        set_regs(16, 0, 1, 500);
        for (k = 0; k < 16; k++)
            push_sample(SAMPLE_TOP, CH_PP, $urandom());
        drain_block();
        // window length above 1024 counts as it is
        set_regs(0, 0, 1025, 1);
        for (k = 0; k < 1025; k++)
            push_sample($urandom_range(0, SAMPLE_TOP), $urandom_range(1), $urandom());
        drain_block();
    endtask

    // Hold the result side off while samples keep coming, so the input backs up.
    task automatic test_backpressure();
        int k;
        set_regs(1, 0, 1, 3);
        send_idle_pct = 0;
        hold_requests++;
        for (k = 0; k < 80; k++)
            push_sample($urandom_range(0, SAMPLE_TOP), $urandom_range(1), $urandom());
        drain_block();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_GROUP_SIZE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        channel   <= CH_CP;
        now_ms    <= '0;
        send_idle_pct = 17;
        recv_idle_pct = 86;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_random_traffic(200);
        send_idle_pct = 86;
        recv_idle_pct = 17;
        test_random_traffic(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);
        test_extreme_registers();
        test_backpressure();
        drain_block();

        if (err_count == 0)
            $display("ev_pilot_level_detector_tb: clean");
        else
            $display("ev_pilot_level_detector_tb: errors");
        $finish;
    end

endmodule
